/* rtl/gb5_pkg.sv */
// Shared types and constants for the 5x5 Gaussian blur block.
package gb5_pkg;
    localparam int unsigned WIN = 5;
    localparam int unsigned HIST = 4;
    localparam int unsigned MAX_FRAME_ROWS = 4096;
    localparam int unsigned NORM_SHIFT = 8;

    localparam logic [0:0] ADDR_ROW_WORDS = 1'b0;
    localparam logic [0:0] ADDR_FRAME_ROWS = 1'b1;

    typedef struct packed {
        logic blur_row;
        logic frame_end;
    } t_ctl;

    function automatic logic [4:0] tap(input int unsigned k);
        logic [4:0] v;
        case (k)
            0, 4: v = 5'd1;
            1, 3: v = 5'd4;
            default: v = 5'd6;
        endcase
        return v;
    endfunction
endpackage

/* rtl/gb5_front.sv */
// Front end: word and row counters, line stores, window word assembly.
module gb5_front import gb5_pkg::*; #(
    parameter int MAX_ROW_WORDS = 64,
    parameter int PIXELS_PER_WORD = 8,
    localparam int WI_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [63:0]           i_pixel_word,
    input  logic [6:0]            i_row_words,
    input  logic [12:0]           i_frame_rows,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [WIN*64-1:0]     o_cur,
    output logic [WIN*64-1:0]     o_left,
    output logic [WI_W-1:0]       o_wi,
    output t_ctl                  o_ctl
);
    logic [63:0] r_mem [HIST][MAX_ROW_WORDS];
    logic [WI_W-1:0] r_wi, n_wi;
    logic [11:0] r_row, n_row;
    logic [63:0] r_left [WIN];
    logic r_valid;
    logic [63:0] r_pix;
    logic [WI_W-1:0] r_swi;
    t_ctl r_ctl;
    logic [63:0] r_rd [HIST];
    logic [63:0] r_pl [WIN];
    logic [10:0] rw, wi_ext;
    logic [12:0] fr;
    logic row_end, fend, adv;
    logic [63:0] cur_w [WIN];
    logic r_wr;
    logic r_re;

    assign adv = !i_stall || !r_valid;

    always_comb begin
        rw = {4'd0, i_row_words};
        if (rw == 11'd0) rw = 11'd1;
        if (rw > 11'(MAX_ROW_WORDS)) rw = 11'(MAX_ROW_WORDS);
        fr = i_frame_rows;
        if (fr == 13'd0) fr = 13'd1;
        if (fr > 13'(MAX_FRAME_ROWS)) fr = 13'(MAX_FRAME_ROWS);
        wi_ext = 11'(r_wi);
        row_end = (wi_ext + 11'd1 >= rw);
        fend = row_end && ({1'b0, r_row} + 13'd1 >= fr);
        n_wi = row_end ? '0 : WI_W'(wi_ext + 11'd1);
        n_row = row_end ? (fend ? 12'd0 : r_row + 12'd1) : r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi <= '0;
            r_row <= '0;
        end else if (i_push) begin
            r_wi <= n_wi;
            r_row <= n_row;
        end
    end

    // Stage 1: read line stores, capture the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < HIST; k++) begin
                r_rd[k] <= (r_wr && r_swi == r_wi) ? cur_w[k+1] : r_mem[k][r_wi];
            end
            r_pix <= i_pixel_word;
            r_swi <= r_wi;
            r_ctl.blur_row <= (r_row >= 12'(HIST));
            r_ctl.frame_end <= fend;
        end
    end

    // Write the shifted column back, bypassing the store of the item in stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
        end else begin
            r_wr <= i_push;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_re <= row_end;
    end

    always_comb begin
        for (int k = 0; k < HIST; k++) cur_w[k] = r_rd[k];
        cur_w[HIST] = r_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            for (int k = 0; k < HIST; k++) r_mem[k][r_swi] <= cur_w[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) r_left[k] <= '0;
        end else if (r_wr) begin
            for (int k = 0; k < WIN; k++) r_left[k] <= r_re ? 64'd0 : cur_w[k];
        end
    end

    always_comb begin
        for (int k = 0; k < WIN; k++) o_cur[k*64 +: 64] = cur_w[k];
    end
    always_comb begin
        for (int k = 0; k < WIN; k++) o_left[k*64 +: 64] = r_left[k];
    end
    assign o_valid = r_valid;
    assign o_wi = r_swi;
    assign o_ctl = r_ctl;
endmodule

/* rtl/gb5_back.sv */
// Back end: 5x5 binomial filter over eight lanes, a vertical pass and a horizontal pass.
module gb5_back import gb5_pkg::*; #(
    parameter int MAX_ROW_WORDS = 64,
    parameter int PIXELS_PER_WORD = 8,
    localparam int WI_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [WIN*64-1:0] i_cur,
    input  logic [WIN*64-1:0] i_left,
    input  logic [WI_W-1:0]   i_wi,
    input  t_ctl              i_ctl,
    input  logic              i_adv,
    output logic              o_valid,
    output logic [63:0]       o_word,
    output logic              o_frame_end
);
    logic [11:0] col_sum [PIXELS_PER_WORD][WIN];
    logic [11:0] r_cs [PIXELS_PER_WORD][WIN];
    logic [7:0] r_px [PIXELS_PER_WORD];
    logic [PIXELS_PER_WORD-1:0] r_pass;
    logic r_fe, r_v;
    logic [63:0] res;
    logic [15:0] s;

    function automatic logic [7:0] pk(input logic [63:0] l, input logic [63:0] c,
                                      input int off);
        logic [7:0] v;
        if (off < 0) v = l[8*(PIXELS_PER_WORD+off) +: 8];
        else v = c[8*off +: 8];
        return v;
    endfunction

    // Vertical pass per lane and window column.
    always_comb begin
        for (int ln = 0; ln < PIXELS_PER_WORD; ln++) begin
            for (int kc = 0; kc < WIN; kc++) begin
                col_sum[ln][kc] = '0;
                for (int kr = 0; kr < WIN; kr++) begin
                    col_sum[ln][kc] = col_sum[ln][kc] + 12'(tap(kr)) * 12'(pk(
                        i_left[kr*64 +: 64], i_cur[kr*64 +: 64], ln - (WIN-1) + kc));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cs <= col_sum;
            r_fe <= i_ctl.frame_end;
            for (int ln = 0; ln < PIXELS_PER_WORD; ln++) begin
                r_px[ln] <= i_cur[HIST*64 + 8*ln +: 8];
                r_pass[ln] <= !i_ctl.blur_row ||
                    ({3'd0, i_wi} * (WI_W+3)'(PIXELS_PER_WORD) + (WI_W+3)'(ln)
                     < (WI_W+3)'(HIST));
            end
        end
    end

    // Horizontal pass and normalize.
    always_comb begin
        res = '0;
        for (int ln = 0; ln < PIXELS_PER_WORD; ln++) begin
            s = '0;
            for (int kc = 0; kc < WIN; kc++) s = s + 16'(tap(kc)) * 16'(r_cs[ln][kc]);
            res[8*ln +: 8] = r_pass[ln] ? r_px[ln] : s[NORM_SHIFT +: 8];
        end
    end

    assign o_valid = r_v;
    assign o_word = res;
    assign o_frame_end = r_fe;
endmodule

/* rtl/gb5_queue.sv */
// Result queue that absorbs the pipeline while the consumer stalls.
module gb5_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [64:0] i_data,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [64:0] o_data,
    output logic [2:0]  o_count
);
    logic [64:0] r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic rd;

    assign rd = i_pop && (r_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, rd};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_wr) r_q[r_wp] <= i_data;
    end

    assign o_empty = (r_cnt == 3'd0);
    assign o_data = r_q[r_rp];
    assign o_count = r_cnt;
endmodule

/* rtl/gaussian_blur_5x5_eight_pixels.sv */
// Top level: 5x5 Gaussian blur on 64-bit words of eight 8-bit pixels.
// Takes one word per cycle while full is low and gives one blurred word per accepted
// word, in order. The line stores are read at the accepting edge, the vertical and
// horizontal filter passes each take one pipeline stage, and a four-entry result queue
// holds results while pop is low; full is high while the queue plus the words in flight
// reach four, so with pop held high words stream with no gap. Configure only while idle.
module gaussian_blur_5x5_eight_pixels import gb5_pkg::*; #(
    parameter int MAX_ROW_WORDS = 64,
    parameter int PIXELS_PER_WORD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_pixel_word,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_blurred_word,
    output logic        o_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int WI_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    logic [6:0] r_row_words;
    logic [12:0] r_frame_rows;
    logic acc, fv, bv;
    logic [WIN*64-1:0] cur, left;
    logic [WI_W-1:0] wi;
    t_ctl ctl;
    logic [63:0] bw;
    logic bfe;
    logic [2:0] cnt;
    logic [64:0] qd;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_words <= 7'd64;
            r_frame_rows <= 13'd512;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (paddr[2])
                ADDR_ROW_WORDS: r_row_words <= pwdata[6:0];
                ADDR_FRAME_ROWS: r_frame_rows <= pwdata[12:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        case (paddr[2])
            ADDR_ROW_WORDS: prdata = {25'd0, r_row_words};
            ADDR_FRAME_ROWS: prdata = {19'd0, r_frame_rows};
            default: prdata = '0;
        endcase
    end

    assign full = ({2'd0, fv} + {2'd0, bv} + cnt) >= 3'd4;
    assign acc = push && !full;

    gb5_front #(.MAX_ROW_WORDS(MAX_ROW_WORDS), .PIXELS_PER_WORD(PIXELS_PER_WORD)) u_front (
        .i_clk, .i_rst_n, .i_push(acc), .i_pixel_word,
        .i_row_words(r_row_words), .i_frame_rows(r_frame_rows), .i_stall(1'b0),
        .o_valid(fv), .o_cur(cur), .o_left(left), .o_wi(wi), .o_ctl(ctl)
    );

    gb5_back #(.MAX_ROW_WORDS(MAX_ROW_WORDS), .PIXELS_PER_WORD(PIXELS_PER_WORD)) u_back (
        .i_clk, .i_rst_n, .i_valid(fv), .i_cur(cur), .i_left(left), .i_wi(wi),
        .i_ctl(ctl), .i_adv(1'b1), .o_valid(bv), .o_word(bw), .o_frame_end(bfe)
    );

    gb5_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(bv), .i_data({bfe, bw}), .i_pop(pop),
        .o_empty(empty), .o_data(qd), .o_count(cnt)
    );

    assign o_blurred_word = qd[63:0];
    assign o_frame_end = qd[64];
endmodule

/* tb/tb_gaussian_blur_5x5_eight_pixels.sv */
// Testbench for the 5x5 Gaussian blur block: random frames checked against a local predictor.
module tb_gaussian_blur_5x5_eight_pixels;
    import gb5_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RW = 64;
    localparam int LANES = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 300;
    localparam logic [2:0] REG_ROW_WORDS = {ADDR_ROW_WORDS, 2'b00};
    localparam logic [2:0] REG_FRAME_ROWS = {ADDR_FRAME_ROWS, 2'b00};

    typedef struct {
        logic [63:0] blurred;
        logic        fend;
    } t_blur_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] i_pixel_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_blurred_word;
    logic        o_frame_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gaussian_blur_5x5_eight_pixels u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_pixel_word(i_pixel_word),
        .empty(empty), .pop(pop), .o_blurred_word(o_blurred_word),
        .o_frame_end(o_frame_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] line_mem [HIST][MAX_RW];
    logic [63:0] prev_word [WIN];
    int unsigned row_idx;
    int unsigned word_idx;
    logic [6:0]  cfg_row_words;
    logic [12:0] cfg_frame_rows;

    t_blur_result blur_q[$];
    int  errors = 0;
    int  sent = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    bit  accepted_in;
    int  quiet_cycles = 0;

    function automatic int unsigned eff_row_words();
        if (cfg_row_words < 1) return 1;
        if (cfg_row_words > MAX_RW) return MAX_RW;
        return cfg_row_words;
    endfunction

    function automatic int unsigned eff_frame_rows();
        if (cfg_frame_rows < 1) return 1;
        if (cfg_frame_rows > MAX_FRAME_ROWS) return MAX_FRAME_ROWS;
        return cfg_frame_rows;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] px_at(logic [63:0] left, logic [63:0] cur, int off);
        if (off < 0) return left[8*(LANES+off) +: 8];
        return cur[8*off +: 8];
    endfunction

    task automatic gauss_predict(input logic [63:0] pixels);
        logic [63:0] win_col [WIN];
        t_blur_result res;
        int unsigned rw, fr, wi, sum;
        bit row_end;
        rw = eff_row_words();
        fr = eff_frame_rows();
        wi = word_idx;
        for (int k = 0; k < HIST; k++) win_col[k] = line_mem[k][wi];
        win_col[HIST] = pixels;
        for (int k = 0; k < HIST; k++) line_mem[k][wi] = win_col[k+1];
        res.blurred = '0;
        for (int l = 0; l < LANES; l++) begin
            if (row_idx < HIST || wi * LANES + l < HIST) begin
                res.blurred[8*l +: 8] = pixels[8*l +: 8];
            end else begin
                sum = 0;
                for (int kr = 0; kr < WIN; kr++)
                    for (int kc = 0; kc < WIN; kc++)
                        sum += px_at(prev_word[kr], win_col[kr], l - HIST + kc)
                               * tap(kr) * tap(kc);
                res.blurred[8*l +: 8] = 8'(sum >> NORM_SHIFT);
            end
        end
        row_end = (wi + 1 >= rw);
        res.fend = row_end && (row_idx + 1 >= fr);
        if (row_end) begin
            for (int k = 0; k < WIN; k++) prev_word[k] = '0;
            word_idx = 0;
            row_idx = res.fend ? 0 : ((row_idx + 1) & 12'hFFF);
        end else begin
            for (int k = 0; k < WIN; k++) prev_word[k] = win_col[k];
            word_idx = wi + 1;
        end
        blur_q.push_back(res);
    endtask

    task automatic send_pixels(input logic [63:0] w);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        gauss_predict(w);
        sent++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return {8{8'($urandom)}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        apb_access(1'b1, addr, data, rd);
        if (addr == REG_ROW_WORDS) cfg_row_words = data[6:0];
        else cfg_frame_rows = data[12:0];
        apb_access(1'b0, addr, '0, rd);
        if (rd[12:0] != ((addr == REG_ROW_WORDS) ? 13'(cfg_row_words) : cfg_frame_rows)) begin
            $display("%0t: register readback at %0d expected %0h actual %0h",
                     $time, addr, data, rd);
            errors++;
        end
    endtask

    task automatic finish_frame();
        while (row_idx != 0 || word_idx != 0) send_pixels(rand_word());
        wait_idle();
    endtask

    // default geometry, then stop in the middle of a row
    task automatic test_defaults();
        logic [31:0] rd;
        apb_access(1'b0, REG_ROW_WORDS, '0, rd);
        if (rd[6:0] != 7'd64) begin
            $display("%0t: row_words reset expected 64 actual %0d", $time, rd);
            errors++;
        end
        apb_access(1'b0, REG_FRAME_ROWS, '0, rd);
        if (rd[12:0] != 13'd512) begin
            $display("%0t: frame_rows reset expected 512 actual %0d", $time, rd);
            errors++;
        end
        repeat (6 * 64 + 10) send_pixels(rand_word());
        wait_idle();
    endtask

    // shrink both registers mid-frame so the counters wrap early
    task automatic test_midframe_change();
        write_cfg(REG_ROW_WORDS, 32'd3);
        write_cfg(REG_FRAME_ROWS, 32'd2);
        repeat (12) send_pixels(rand_word());
        wait_idle();
    endtask

    task automatic test_directed();
        write_cfg(REG_ROW_WORDS, 32'd1);
        write_cfg(REG_FRAME_ROWS, 32'd6);
        send_pixels('0);
        send_pixels('1);
        send_pixels(64'hAA55_AA55_AA55_AA55);
        send_pixels(64'h0102_0408_1020_4080);
        send_pixels('1);
        send_pixels('0);
        wait_idle();
        write_cfg(REG_ROW_WORDS, 32'd2);
        write_cfg(REG_FRAME_ROWS, 32'd5);
        repeat (10) send_pixels('1);
        wait_idle();
        write_cfg(REG_ROW_WORDS, 32'd0);
        write_cfg(REG_FRAME_ROWS, 32'd0);
        repeat (3) send_pixels(rand_word());
        wait_idle();
        write_cfg(REG_ROW_WORDS, 32'h7F);
        write_cfg(REG_FRAME_ROWS, 32'd1);
        repeat (64) send_pixels(rand_word());
        wait_idle();
        write_cfg(REG_ROW_WORDS, 32'd1);
        write_cfg(REG_FRAME_ROWS, 32'h1FFF);
        repeat (8) send_pixels(rand_word());
        wait_idle();
        write_cfg(REG_FRAME_ROWS, 32'd10);
        finish_frame();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        write_cfg(REG_ROW_WORDS, 32'd4);
        write_cfg(REG_FRAME_ROWS, 32'd8);
        no_idle = 1'b1;
        hold_req = 1'b1;
        repeat (32) send_pixels(rand_word());
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int target;
        target = sent + 1500;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) write_cfg(REG_ROW_WORDS, $urandom_range(9, 64));
            else write_cfg(REG_ROW_WORDS, $urandom_range(1, 8));
            write_cfg(REG_FRAME_ROWS, $urandom_range(1, 12));
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0) hold_req = 1'b1;
            repeat ($urandom_range(1, 2) * eff_row_words() * eff_frame_rows())
                send_pixels(rand_word());
            no_idle = 1'b0;
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        int g;
        if (hold_req) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge i_clk);
            hold_req = 1'b0;
        end else begin
            g = gap_len();
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g - 1) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_blur_result want;
        accepted_in = i_rst_n && ((push && !full) || (pop && !empty));
        if (i_rst_n && pop && !empty) begin
            if (blur_q.size() == 0) begin
                $display("%0t: unexpected result %h end %b", $time, o_blurred_word,
                         o_frame_end);
                errors++;
            end else begin
                want = blur_q.pop_front();
                if (o_blurred_word !== want.blurred) begin
                    $display("%0t: blurred_word expected %h actual %h", $time,
                             want.blurred, o_blurred_word);
                    errors++;
                end
                if (o_frame_end !== want.fend) begin
                    $display("%0t: frame_end expected %b actual %b", $time, want.fend,
                             o_frame_end);
                    errors++;
                end
            end
        end
        quiet_cycles = accepted_in ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < WIN; k++) prev_word[k] = '0;
        row_idx = 0;
        word_idx = 0;
        cfg_row_words = 7'd64;
        cfg_frame_rows = 13'd512;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_midframe_change();
        test_directed();
        test_backpressure();
        test_random_frames();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && blur_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
